// ----- rtl/tli_pkg.sv -----
// Shared types and constants of the table linear interpolator.
`timescale 1ns / 1ps
`default_nettype none

package tli_pkg;

	// Breakpoint table geometry.
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	// Field widths fixed by the stream format.
	localparam int PT_W        = 6;
	localparam int LIDX_W      = 6;
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 32;

	// Request kinds carried on the input tuser.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Result status codes carried on the output tuser.
	localparam logic [1:0] STAT_IN_RANGE  = 2'd0;
	localparam logic [1:0] STAT_BELOW     = 2'd1;
	localparam logic [1:0] STAT_ABOVE     = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	// Input tdata layout; the last member, point_index, sits in the lowest bits.
	typedef struct packed {
		logic [1:0]         pad;
		logic signed [31:0] query_x;
		logic signed [31:0] load_y;
		logic signed [31:0] load_x;
		logic [PT_W-1:0]    point_index;
	} in_data_t;

	// One table entry as stored in the memory.
	typedef struct packed {
		logic signed [31:0] y;
		logic signed [31:0] x;
	} point_t;

	// Request to the multiply-divide unit: start with operands.
	typedef struct packed {
		logic        start;
		logic [32:0] mag;
		logic [31:0] dq;
		logic [31:0] dx;
	} md_req_t;

	// Response from the multiply-divide unit.
	typedef struct packed {
		logic        busy;
		logic        done;
		logic [32:0] quot;
	} md_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/tli_muldiv.sv -----
// Iterative unit that computes floor(mag * dq / dx) on one shared 34-bit adder.
`timescale 1ns / 1ps
`default_nettype none

module tli_muldiv
	import tli_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire md_req_t req,
	output md_rsp_t      rsp
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_MUL   = 2'd1;
	localparam logic [1:0] PH_ALIGN = 2'd2;
	localparam logic [1:0] PH_DIV   = 2'd3;

	localparam logic [5:0] MUL_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST = 6'd32;

	logic [1:0]  phase_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [32:0] mag_q;
	logic [31:0] dx_q;
	logic [32:0] a_q;
	logic [32:0] b_q;

	logic [32:0] div_t;
	logic [33:0] op_a;
	logic [33:0] op_b;
	logic        op_sub;
	logic [33:0] sum;
	logic        ge;

	// Shared adder: shift-add multiply or restoring divide step.
	always_comb begin
		div_t  = {a_q[31:0], b_q[32]};
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		unique case (phase_q)
			PH_MUL: begin
				op_a = {1'b0, a_q};
				op_b = b_q[0] ? {1'b0, mag_q} : '0;
			end
			PH_DIV: begin
				op_a   = {1'b0, div_t};
				op_b   = {2'b00, dx_q};
				op_sub = 1'b1;
			end
			default: begin
				op_sub = 1'b0;
			end
		endcase
		sum = op_sub ? (op_a - op_b) : (op_a + op_b);
		ge  = ~sum[33];
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						phase_q <= PH_MUL;
						cnt_q   <= '0;
					end
				end
				PH_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == MUL_LAST) begin
						phase_q <= PH_ALIGN;
					end
				end
				PH_ALIGN: begin
					cnt_q   <= '0;
					phase_q <= PH_DIV;
				end
				PH_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	// Datapath: product builds in {a, b}, then the quotient shifts into b.
	always_ff @(posedge clk) begin
		unique case (phase_q)
			PH_IDLE: begin
				if (req.start) begin
					mag_q <= req.mag;
					dx_q  <= req.dx;
					a_q   <= '0;
					b_q   <= {1'b0, req.dq};
				end
			end
			PH_MUL: begin
				a_q <= sum[33:1];
				b_q <= {1'b0, sum[0], b_q[31:1]};
			end
			PH_ALIGN: begin
				a_q <= {2'b00, a_q[31:1]};
				b_q <= {a_q[0], b_q[31:0]};
			end
			PH_DIV: begin
				a_q <= ge ? sum[32:0] : div_t;
				b_q <= {b_q[31:0], ge};
			end
			default: begin
				a_q <= a_q;
			end
		endcase
	end

	assign rsp.busy = (phase_q != PH_IDLE);
	assign rsp.done = done_q;
	assign rsp.quot = b_q;

	// The partial remainder always stays below the divisor.
	a_rem_below_dx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DIV) |-> (a_q < {1'b0, dx_q}))
		else $error("divide remainder not below divisor");

	// A start is only issued while the unit is free.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (phase_q == PH_IDLE))
		else $error("start while busy");

	// Done follows the last divide step.
	a_done_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(phase_q) == PH_DIV && $past(cnt_q) == DIV_LAST))
		else $error("done without finishing the divide");

endmodule

`default_nettype wire

// ----- rtl/table_linear_interpolator_core.sv -----
// Top level of the piecewise linear interpolation table.
//
// The block holds a table of breakpoints (x ascending, y), both signed Q16.16,
// in one memory of TABLE_DEPTH entries; entries are valid only once loaded.
// A load request (tuser 0) writes one breakpoint and gives no
// result. A query request (tuser 1) gives one result: below the first
// breakpoint it returns the first y with status 1, above the breakpoint at
// last_index it returns that y with status 2, otherwise it scans segments from
// the start, one memory read per cycle, and interpolates in the first segment
// that holds the query; a zero-width segment returns its left y and a failed
// search returns 0 with status 3. Interpolation uses a 32-step shift-add
// multiply and a 33-step restoring divide on one shared adder. The block
// takes one request at a time; a finished result waits in the output
// register while the next request is accepted. The interpolated result
// saturates to 32 bits.
`timescale 1ns / 1ps
`default_nettype none

module table_linear_interpolator_core
	import tli_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration: last_index.
	input  wire logic                   cfg_wr_en,
	input  wire logic [LIDX_W-1:0]      cfg_wr_data,
	// Request stream.
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// s_tdata: point_index[5:0], load_x[37:6], load_y[69:38], query_x[101:70], zeros
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// s_tuser: func[0]
	input  wire logic                   s_tuser,
	// Result stream.
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// m_tdata: y_out[31:0]
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// m_tuser: status[1:0]
	output logic [1:0]                  m_tuser
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK0 = 3'd1;
	localparam logic [2:0] S_CHKN = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_CALC = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]         state_q;
	logic [LIDX_W-1:0]  last_index_q;
	logic [IDX_W-1:0]   n_q;
	logic [IDX_W-1:0]   j_q;
	logic signed [31:0] xq_q;
	point_t             prev_q;
	point_t             rdata_q;
	logic signed [31:0] y0_q;
	logic               neg_q;
	logic [31:0]        res_y_q;
	logic [1:0]         res_st_q;
	logic               m_tvalid_q;
	logic [31:0]        m_y_q;
	logic [1:0]         m_st_q;

	point_t             pt_mem [TABLE_DEPTH];

	in_data_t           in_d;
	logic               accept;
	logic               mem_we;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   n_clamp;
	logic               out_free;
	logic               seg_hit;
	logic signed [32:0] dx33;
	logic signed [32:0] dq33;
	logic signed [32:0] dy33;
	logic [32:0]        mag33;
	logic signed [33:0] res34;
	logic [31:0]        y_sat;
	md_req_t            md_req;
	md_rsp_t            md_rsp;

	assign in_d     = in_data_t'(s_tdata);
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign mem_we   = accept && (s_tuser == FUNC_LOAD) &&
		(32'(in_d.point_index) < TABLE_DEPTH);
	assign out_free = ~m_tvalid_q | m_tready;

	// Effective last breakpoint: zero reads as one, large values clamp to the table.
	always_comb begin
		if (last_index_q == '0) begin
			n_clamp = IDX_W'(1);
		end else if (32'(last_index_q) > TABLE_DEPTH - 1) begin
			n_clamp = IDX_W'(TABLE_DEPTH - 1);
		end else begin
			n_clamp = IDX_W'(last_index_q);
		end
	end

	// Read address for the next cycle's table entry.
	always_comb begin
		unique case (state_q)
			S_CHK0:  rd_addr = n_q;
			S_CHKN:  rd_addr = IDX_W'(1);
			S_SCAN:  rd_addr = j_q + IDX_W'(1);
			default: rd_addr = '0;
		endcase
	end

	// Breakpoint memory, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pt_mem[IDX_W'(in_d.point_index)] <= {in_d.load_y, in_d.load_x};
		end
		rdata_q <= pt_mem[rd_addr];
	end

	// Segment test and the differences that feed the divide unit.
	always_comb begin
		seg_hit = (xq_q >= prev_q.x) && (xq_q <= rdata_q.x);
		dx33    = {rdata_q.x[31], rdata_q.x} - {prev_q.x[31], prev_q.x};
		dq33    = {xq_q[31], xq_q} - {prev_q.x[31], prev_q.x};
		dy33    = {rdata_q.y[31], rdata_q.y} - {prev_q.y[31], prev_q.y};
		mag33   = dy33[32] ? 33'(-dy33) : 33'(dy33);

		md_req.start = (state_q == S_SCAN) && seg_hit && (dx33 != '0);
		md_req.mag   = mag33;
		md_req.dq    = dq33[31:0];
		md_req.dx    = dx33[31:0];
	end

	tli_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// Apply the signed quotient to the left y and saturate to 32 bits.
	always_comb begin
		if (neg_q) begin
			res34 = {{2{y0_q[31]}}, y0_q} - $signed({1'b0, md_rsp.quot});
		end else begin
			res34 = {{2{y0_q[31]}}, y0_q} + $signed({1'b0, md_rsp.quot});
		end
		if (res34 > 34'sd2147483647) begin
			y_sat = 32'h7FFF_FFFF;
		end else if (res34 < -34'sd2147483648) begin
			y_sat = 32'h8000_0000;
		end else begin
			y_sat = res34[31:0];
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= LIDX_W'(1);
		end else if (cfg_wr_en) begin
			last_index_q <= cfg_wr_data;
		end
	end

	// Query sequencer and output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (s_tuser == FUNC_QUERY)) begin
						state_q <= S_CHK0;
					end
				end
				S_CHK0: begin
					state_q <= (xq_q < rdata_q.x) ? S_DONE : S_CHKN;
				end
				S_CHKN: begin
					state_q <= (xq_q > rdata_q.x) ? S_DONE : S_SCAN;
				end
				S_SCAN: begin
					if (md_req.start) begin
						state_q <= S_CALC;
					end else if (seg_hit || (j_q == n_q)) begin
						state_q <= S_DONE;
					end
				end
				S_CALC: begin
					if (md_rsp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// The result is raised on hand-off and dropped once it is taken.
			if ((state_q == S_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Query payload registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					xq_q <= in_d.query_x;
					n_q  <= n_clamp;
				end
			end
			S_CHK0: begin
				prev_q   <= rdata_q;
				res_y_q  <= rdata_q.y;
				res_st_q <= STAT_BELOW;
			end
			S_CHKN: begin
				j_q      <= IDX_W'(1);
				res_y_q  <= rdata_q.y;
				res_st_q <= STAT_ABOVE;
			end
			S_SCAN: begin
				y0_q  <= prev_q.y;
				neg_q <= dy33[32];
				if (seg_hit) begin
					res_y_q  <= prev_q.y;
					res_st_q <= STAT_IN_RANGE;
				end else begin
					res_y_q  <= '0;
					res_st_q <= STAT_NOT_FOUND;
				end
				prev_q <= rdata_q;
				j_q    <= j_q + IDX_W'(1);
			end
			S_CALC: begin
				if (md_rsp.done) begin
					res_y_q <= y_sat;
				end
			end
			S_DONE: begin
				if (out_free) begin
					m_y_q  <= res_y_q;
					m_st_q <= res_st_q;
				end
			end
			default: begin
				j_q <= j_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_y_q;
	assign m_tuser  = m_st_q;

	// The divide unit only finishes while a query waits on it.
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == S_CALC))
		else $error("divide result with no query waiting");

	// The divide unit only runs while a query waits on it.
	a_busy_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.busy |-> (state_q == S_CALC))
		else $error("divide unit running with no query waiting");

	// The scan index stays inside the active segments.
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (j_q != '0 && j_q <= n_q))
		else $error("scan index outside the table");

	// A new result is only raised from the hand-off state.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside hand-off");

	// A query in flight always has a nonzero last breakpoint.
	a_n_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (n_q != '0))
		else $error("query with empty segment range");

endmodule

`default_nettype wire
